// ----- src/u16u8_pkg.sv -----
// Shared types, constants and UTF-8 helper functions for the UTF-16 to UTF-8 encoder.
`default_nettype none
package u16u8_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int CSR_INDEX_W     = 1;
   localparam int COUNT_W         = 32;
   localparam int CP_W            = 21;

   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_ENABLED = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_LIMIT    = 1'b1;

   localparam logic [5:0]      SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0]      SURR_LOW_TAG  = 6'b110111;
   localparam logic [CP_W-1:0] CP_REPLACE    = 21'h00FFFD;
   localparam logic [CP_W-1:0] CP_SUPP_BASE  = 21'h010000;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BUDGET   = 2'd1,
      STATUS_UNPAIRED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CP0,
      PH_CP1,
      PH_STAT
   } phase_type;

   // Work for one accepted unit: up to two code points, then an optional status result.
   typedef struct packed {
      logic               last;
      logic [COUNT_W-1:0] base;
      logic               e0_v;
      logic [CP_W-1:0]    cp0;
      logic [2:0]         n0;
      logic               e1_v;
      logic [CP_W-1:0]    cp1;
      logic [2:0]         n1;
      logic               st_v;
      status_type         st;
   } desc_type;

   function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
      logic [2:0] n;
      if (cp[20:16] != 5'd0) begin
         n = 3'd4;
      end else if (cp[15:11] != 5'd0) begin
         n = 3'd3;
      end else if (cp[10:7] != 4'd0) begin
         n = 3'd2;
      end else begin
         n = 3'd1;
      end
      return n;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                            input logic [2:0] n,
                                            input logic [1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      unique case (n)
         3'd1: b = {1'b0, cp[6:0]};
         3'd2: begin
            unique case (idx)
               2'd0:    b = {3'b110, cp[10:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         3'd3: begin
            unique case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            unique case (idx)
               2'd0: b = {5'b11110, cp[20:18]};
               2'd1: b = {2'b10, cp[17:12]};
               2'd2: b = {2'b10, cp[11:6]};
               2'd3: b = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ----- src/u16u8_front.sv -----
// Front end: config registers, surrogate pairing, budget checks, work descriptors.
`default_nettype none
module u16u8_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [u16u8_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                       csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [15:0]                       req_code_unit,
   input  wire logic                              req_last_unit,
   input  wire logic                              q_full,
   output logic                                   push,
   output u16u8_pkg::desc_type                    push_desc
);
   import u16u8_pkg::*;

   logic               limit_en_ff;
   logic [31:0]        limit_ff;
   logic               pend_ff, pend_in;
   logic [9:0]         pend_hi_ff, pend_hi_in;
   logic [31:0]        bw_ff, bw_in;
   status_type         fail_ff, fail_in;

   logic               accept;
   logic               is_hi, is_lo, had_fail;
   logic               e0_try, over0, e0_v, unit_done;
   logic               try1, emit1_try, over1, e1_v;
   logic               store_pend, fail2;
   logic [CP_W-1:0]    cp0, cp1;
   logic [2:0]         n0, n1;
   logic [3:0]         n01;
   logic [32:0]        sum0, sum1a, sum1b, sum1;
   status_type         new_fail;
   logic               st_v;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_en_ff <= 1'b0;
         limit_ff    <= 32'd0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LIMIT_ENABLED: limit_en_ff <= csr_wdata[0];
            CSR_BYTE_LIMIT:    limit_ff    <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      is_hi    = req_code_unit[15:10] == SURR_HIGH_TAG;
      is_lo    = req_code_unit[15:10] == SURR_LOW_TAG;
      had_fail = fail_ff != STATUS_OK;

      // held high surrogate resolves first: pair or replacement char
      e0_try    = !had_fail && pend_ff;
      cp0       = is_lo ? ({1'b0, pend_hi_ff, req_code_unit[9:0]} + CP_SUPP_BASE)
                        : CP_REPLACE;
      n0        = is_lo ? 3'd4 : 3'd3;
      sum0      = {1'b0, bw_ff} + 33'(n0);
      over0     = limit_en_ff && (sum0 > {1'b0, limit_ff});
      e0_v      = e0_try && !over0;
      unit_done = e0_try && is_lo;

      try1       = !had_fail && !(e0_try && over0) && !unit_done;
      cp1        = is_lo ? CP_REPLACE : {5'd0, req_code_unit};
      n1         = utf8_len(cp1);
      n01        = {1'b0, n0} + {1'b0, n1};
      sum1a      = {1'b0, bw_ff} + 33'(n1);
      sum1b      = {1'b0, bw_ff} + 33'(n01);
      sum1       = e0_v ? sum1b : sum1a;
      emit1_try  = try1 && !is_hi;
      over1      = limit_en_ff && (sum1 > {1'b0, limit_ff});
      e1_v       = emit1_try && !over1;
      fail2      = try1 && is_hi && req_last_unit;
      store_pend = try1 && is_hi && !req_last_unit;

      priority if (had_fail) begin
         new_fail = fail_ff;
      end else if ((e0_try && over0) || (emit1_try && over1)) begin
         new_fail = STATUS_BUDGET;
      end else if (fail2) begin
         new_fail = STATUS_UNPAIRED;
      end else begin
         new_fail = STATUS_OK;
      end
      st_v = had_fail ? req_last_unit : (new_fail != STATUS_OK);

      push = accept && (e0_v || e1_v || st_v);

      push_desc.last = req_last_unit;
      push_desc.base = bw_ff;
      push_desc.e0_v = e0_v;
      push_desc.cp0  = cp0;
      push_desc.n0   = n0;
      push_desc.e1_v = e1_v;
      push_desc.cp1  = cp1;
      push_desc.n1   = n1;
      push_desc.st_v = st_v;
      push_desc.st   = new_fail;

      pend_in    = pend_ff;
      pend_hi_in = pend_hi_ff;
      bw_in      = bw_ff;
      fail_in    = fail_ff;
      if (accept) begin
         if (req_last_unit) begin
            pend_in    = 1'b0;
            pend_hi_in = 10'd0;
            bw_in      = 32'd0;
            fail_in    = STATUS_OK;
         end else begin
            pend_in    = store_pend;
            pend_hi_in = store_pend ? req_code_unit[9:0] : 10'd0;
            fail_in    = new_fail;
            priority if (e1_v) begin
               bw_in = sum1[31:0];
            end else if (e0_v) begin
               bw_in = sum0[31:0];
            end else begin
               bw_in = bw_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         pend_hi_ff <= 10'd0;
         bw_ff      <= 32'd0;
         fail_ff    <= STATUS_OK;
      end else begin
         pend_ff    <= pend_in;
         pend_hi_ff <= pend_hi_in;
         bw_ff      <= bw_in;
         fail_ff    <= fail_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/u16u8_queue.sv -----
// Short descriptor queue between front end and byte serializer.
`default_nettype none
module u16u8_queue #(
   parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire u16u8_pkg::desc_type  push_desc,
   input  wire logic                 pop,
   output logic                      head_valid,
   output u16u8_pkg::desc_type       head_desc,
   output logic                      full
);
   import u16u8_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_desc  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule
`default_nettype wire

// ----- src/u16u8_back.sv -----
// Back end: walks a descriptor and emits one UTF-8 byte or status result per cycle while rsp_stall does not hold it.
`default_nettype none
module u16u8_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire u16u8_pkg::desc_type  head_desc,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_byte_valid,
   output logic                      rsp_last_of_run,
   output logic                      rsp_string_done,
   output logic [1:0]                rsp_status,
   output logic [31:0]               rsp_byte_count
);
   import u16u8_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [1:0]       idx_ff, idx_in;
   logic [31:0]      count_ff, count_in;

   logic             out_free, fire;
   phase_type        cur_ph, first_ph, after_ph;
   logic [CP_W-1:0]  cp;
   logic [2:0]       n;
   logic             is_byte, ph_end, item_end;
   logic [31:0]      cnt, cnt_out;
   logic [7:0]       byte_out;

   logic             rsp_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             byte_valid_ff, last_run_ff, str_done_ff;
   logic [1:0]       status_ff;
   logic [31:0]      byte_count_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = head_valid && out_free;

   // output side: what the current step of the descriptor produces
   always_comb begin
      priority if (head_desc.e0_v) begin
         first_ph = PH_CP0;
      end else if (head_desc.e1_v) begin
         first_ph = PH_CP1;
      end else begin
         first_ph = PH_STAT;
      end
      cur_ph = (phase_ff == PH_IDLE) ? first_ph : phase_ff;
      cnt    = (phase_ff == PH_IDLE) ? head_desc.base : count_ff;

      unique case (cur_ph)
         PH_CP0: begin
            cp       = head_desc.cp0;
            n        = head_desc.n0;
            is_byte  = 1'b1;
            after_ph = head_desc.e1_v ? PH_CP1 : (head_desc.st_v ? PH_STAT : PH_IDLE);
         end
         PH_CP1: begin
            cp       = head_desc.cp1;
            n        = head_desc.n1;
            is_byte  = 1'b1;
            after_ph = head_desc.st_v ? PH_STAT : PH_IDLE;
         end
         PH_STAT, PH_IDLE: begin
            cp       = '0;
            n        = 3'd1;
            is_byte  = 1'b0;
            after_ph = PH_IDLE;
         end
      endcase

      byte_out = is_byte ? utf8_byte(cp, n, idx_ff) : 8'h00;
      ph_end   = !is_byte || (({1'b0, idx_ff} + 3'd1) == n);
      item_end = ph_end && (after_ph == PH_IDLE);
      cnt_out  = is_byte ? cnt + 32'd1 : cnt;
      pop      = fire && item_end;
   end

   // next state of the descriptor walk
   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      if (fire) begin
         count_in = cnt_out;
         if (item_end) begin
            phase_in = PH_IDLE;
            idx_in   = 2'd0;
         end else if (ph_end) begin
            phase_in = after_ph;
            idx_in   = 2'd0;
         end else begin
            phase_in = cur_ph;
            idx_in   = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff   <= byte_out;
         byte_valid_ff <= is_byte;
         last_run_ff   <= item_end;
         str_done_ff   <= item_end && head_desc.last;
         status_ff     <= is_byte ? STATUS_OK : head_desc.st;
         byte_count_ff <= cnt_out;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_byte_valid  = byte_valid_ff;
   assign rsp_last_of_run = last_run_ff;
   assign rsp_string_done = str_done_ff;
   assign rsp_status      = status_ff;
   assign rsp_byte_count  = byte_count_ff;

endmodule
`default_nettype wire

// ----- src/utf16_to_utf8_encoder.sv -----
// Top level of the UTF-16 to UTF-8 encoder: front end, descriptor queue, byte serializer.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_code_unit, req_last_unit
//   rsp      out        rsp_valid / rsp_stall  rsp_out_byte, rsp_byte_valid, rsp_last_of_run,
//                                              rsp_string_done, rsp_status, rsp_byte_count
//   csr      in         csr_write_en           csr_index, csr_wdata
//
// A unit causes 0 to 6 results, usually 1 to 3. The serializer, one result per cycle
// while rsp_stall does not hold it, sets the sustained rate; the front end takes one unit
// per cycle while the QUEUE_DEPTH-entry descriptor queue has room.
// Synchronous reset clears control state and both config registers, but not data registers.
// rsp_stall holds the output register; a full queue raises req_stall.
`default_nettype none
module utf16_to_utf8_encoder #(
   parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [u16u8_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                       csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [15:0]                       req_code_unit,
   input  wire logic                              req_last_unit,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [7:0]                             rsp_out_byte,
   output logic                                   rsp_byte_valid,
   output logic                                   rsp_last_of_run,
   output logic                                   rsp_string_done,
   output logic [1:0]                             rsp_status,
   output logic [31:0]                            rsp_byte_count
);
   import u16u8_pkg::*;

   logic      q_full, push, pop, head_valid;
   desc_type  push_desc, head_desc;

   u16u8_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_code_unit (req_code_unit),
      .req_last_unit (req_last_unit),
      .q_full        (q_full),
      .push          (push),
      .push_desc     (push_desc)
   );

   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .full       (q_full)
   );

   u16u8_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_desc       (head_desc),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_string_done (rsp_string_done),
      .rsp_status      (rsp_status),
      .rsp_byte_count  (rsp_byte_count)
   );

endmodule
`default_nettype wire

// ----- src/u16u8_checker.sv -----
// Port-level checks for the encoder, bound to the top level.
`default_nettype none
module u16u8_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_byte_valid,
   input wire logic        rsp_last_of_run,
   input wire logic        rsp_string_done,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_byte_count
);
   import u16u8_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_count) && $stable(rsp_status))
      else $error("stalled result changed");

   a_status_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last_of_run && rsp_status != STATUS_OK)
      else $error("status result not final or has ok status");

   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_status == STATUS_OK)
      else $error("byte result carries a failure status");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_done |-> rsp_last_of_run)
      else $error("string_done without last_of_run");

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_byte_valid  (rsp_byte_valid),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_string_done (rsp_string_done),
   .rsp_status      (rsp_status),
   .rsp_byte_count  (rsp_byte_count)
);
`default_nettype wire
